// ----- src/kv_page_eviction_manager_core_defines.svh -----
// Assertion macros used by the checker file.
`ifndef KV_PAGE_EVICTION_MANAGER_CORE_DEFINES_SVH
`define KV_PAGE_EVICTION_MANAGER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KVPEM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KVPEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds through reset.
`define KVPEM_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/kvpem_pkg.sv -----
package kvpem_pkg;

    // Default sizing of the page table.
    localparam int NUM_PAGES_DEF   = 256;
    localparam int PAGE_TOKENS_DEF = 16;

    // Field widths.
    localparam int OP_W    = 2;
    localparam int TOKEN_W = 12;
    localparam int SCORE_W = 16;
    localparam int CNT_W   = 9;
    localparam int PIN_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [PIN_W-1:0] PIN_MAX = 8'hFF;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESIDENT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EVICTION_BAND = 1'b1;
    localparam logic [CNT_W-1:0] MAX_RESIDENT_RST  = 9'd256;
    localparam logic [CNT_W-1:0] EVICTION_BAND_RST = 9'd8;

    typedef enum logic [OP_W-1:0] {
        OP_TOUCH = 2'd0,
        OP_EVICT = 2'd1,
        OP_PIN   = 2'd2,
        OP_UNPIN = 2'd3
    } t_op;

    // One page table entry as stored in memory.
    typedef struct packed {
        logic [PIN_W-1:0]   pins;
        logic               present;
        logic [SCORE_W-1:0] score;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clear;
        logic div_step;
        logic scan_step;
        logic load_tgt;
        logic ev_write;
        logic apply_rd;
        logic apply_ent;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic scan_last;
        logic is_touch;
        logic is_evict;
        logic present;
        logic trigger;
        logic tgt_zero;
        logic ev_more;
        logic out_free;
    } t_sts;

endpackage

// ----- src/kvpem_req_if.sv -----
interface kvpem_req_if import kvpem_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [TOKEN_W-1:0] token_id;
    logic [SCORE_W-1:0] attn_wt;
    logic [CNT_W-1:0]   evict_count;

    modport source (output valid, operation, token_id, attn_wt, evict_count,
                    input ready);
    modport sink   (input valid, operation, token_id, attn_wt, evict_count,
                    output ready);
endinterface

// ----- src/kvpem_rsp_if.sv -----
interface kvpem_rsp_if import kvpem_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] evicted_pages;
    logic [CNT_W-1:0] resident_pages;

    modport source (output valid, evicted_pages, resident_pages, input ready);
    modport sink   (input valid, evicted_pages, resident_pages, output ready);
endinterface

// ----- src/kv_page_eviction_manager_core.sv -----
// Channel    Role    Transaction
// i_req      sink    operation, token_id, attn_wt, evict_count
// o_rsp      source  evicted_pages, resident_pages
//
// Pin, unpin, evict of zero and a touch without eviction pass from one accepted transaction
// to the next through three steps for the page number, a memory read, the look-up with its
// write, if any, the result load and the return to idle. A scan of the table memory steps
// over every page, drains the last read and writes out the best candidate, if any; there is
// one scan per page evicted, plus one that comes up empty when candidates run out. A touch
// that evicts adds one write. After reset a clearing pass over all pages runs before
// i_req.ready rises. A stalled o_rsp holds its result; the next request is taken once it is queued.
module kv_page_eviction_manager_core import kvpem_pkg::*; #(
    parameter int NUM_PAGES   = NUM_PAGES_DEF,
    parameter int PAGE_TOKENS = PAGE_TOKENS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CNT_W-1:0]     i_cfg_data,
    kvpem_req_if.sink            i_req,
    kvpem_rsp_if.source          o_rsp
);
    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    kvpem_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Page table, page number unit, scan and result register.
    kvpem_datapath #(.NUM_PAGES(NUM_PAGES), .PAGE_TOKENS(PAGE_TOKENS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_operation      (i_req.operation),
        .i_token_id       (i_req.token_id),
        .i_attn_wt        (i_req.attn_wt),
        .i_evict_count    (i_req.evict_count),
        .o_rsp_valid      (o_rsp.valid),
        .i_rsp_ready      (o_rsp.ready),
        .o_evicted_pages  (o_rsp.evicted_pages),
        .o_resident_pages (o_rsp.resident_pages)
    );
endmodule

// ----- src/kvpem_ram.sv -----
module kvpem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/kvpem_ctrl.sv -----
module kvpem_ctrl import kvpem_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [9:0] {
        S_CLEAR   = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_DIV     = 10'b0000000100,
        S_READ    = 10'b0000001000,
        S_LOOK    = 10'b0000010000,
        S_SCAN    = 10'b0000100000,
        S_DRAIN   = 10'b0001000000,
        S_EVWR    = 10'b0010000000,
        S_TOUCHWR = 10'b0100000000,
        S_FIN     = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOOK;
            end
            S_LOOK: begin
                if (i_sts.is_evict || (i_sts.is_touch && !i_sts.present && i_sts.trigger)) begin
                    o_cmd.load_tgt = 1'b1;
                    if (!i_sts.tgt_zero) begin
                        n_state = S_SCAN;
                    end else if (i_sts.is_touch) begin
                        n_state = S_TOUCHWR;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    o_cmd.apply_rd = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EVWR;
            end
            S_EVWR: begin
                o_cmd.ev_write = 1'b1;
                if (i_sts.ev_more) begin
                    n_state = S_SCAN;
                end else if (i_sts.is_touch) begin
                    n_state = S_TOUCHWR;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_TOUCHWR: begin
                o_cmd.apply_ent = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end
endmodule

// ----- src/kvpem_datapath.sv -----
module kvpem_datapath import kvpem_pkg::*; #(
    parameter int NUM_PAGES   = NUM_PAGES_DEF,
    parameter int PAGE_TOKENS = PAGE_TOKENS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CNT_W-1:0]     i_cfg_data,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [TOKEN_W-1:0]   i_token_id,
    input  logic [SCORE_W-1:0]   i_attn_wt,
    input  logic [CNT_W-1:0]     i_evict_count,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_ready,
    output logic [CNT_W-1:0]     o_evicted_pages,
    output logic [CNT_W-1:0]     o_resident_pages
);
    localparam int PW   = $clog2(NUM_PAGES);
    localparam int TW   = $clog2(NUM_PAGES + 1);
    localparam int CMPW = (TW > CNT_W) ? TW : CNT_W;
    localparam logic [PW-1:0] PG_LAST = PW'(NUM_PAGES - 1);

    // Reciprocal constants: floor(x / d) = (x * ceil(2^s / d)) >> s for every
    // TOKEN_W-bit x when s = TOKEN_W + ceil(log2(d)).
    localparam int MW  = TOKEN_W + 1;
    localparam int QSH = TOKEN_W + $clog2(PAGE_TOKENS);
    localparam int NSH = TOKEN_W + $clog2(NUM_PAGES);
    localparam int QPW = QSH + TOKEN_W + 1;
    localparam int NPW = NSH + TOKEN_W + 1;
    localparam int DW  = TOKEN_W + MW;
    localparam logic [MW-1:0] Q_MUL = MW'(((1 << QSH) + PAGE_TOKENS - 1) / PAGE_TOKENS);
    localparam logic [MW-1:0] N_MUL = MW'(((1 << NSH) + NUM_PAGES - 1) / NUM_PAGES);
    localparam logic [MW-1:0] NP_W  = MW'(NUM_PAGES);
    localparam logic [1:0]    DPH_QUO  = 2'd0;
    localparam logic [1:0]    DPH_NUM  = 2'd1;
    localparam logic [1:0]    DPH_LAST = 2'd2;

    // Configuration registers.
    logic [CNT_W-1:0] r_max_res, r_band;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_res <= MAX_RESIDENT_RST;
            r_band    <= EVICTION_BAND_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_RESIDENT:  r_max_res <= i_cfg_data;
                CFG_EVICTION_BAND: r_band    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Latched request fields.
    t_op              r_op;
    logic [SCORE_W-1:0] r_weight;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= t_op'(i_operation);
            r_weight <= i_attn_wt;
            r_count  <= i_evict_count;
        end
    end

    // Page number in three steps: the quotient by the page size, the quotient
    // of that by the table size, then the remainder by back-multiplication.
    logic [TOKEN_W-1:0] r_tok, r_quo, r_qnp;
    logic [1:0]         r_dph;
    logic [PW-1:0]      r_page;
    logic [QPW-1:0]     quo_prod;
    logic [NPW-1:0]     qnp_prod;
    logic [DW-1:0]      np_prod, pg_rem;

    assign quo_prod = QPW'(r_tok) * QPW'(Q_MUL);
    assign qnp_prod = NPW'(r_quo) * NPW'(N_MUL);
    assign np_prod  = DW'(r_qnp) * DW'(NP_W);
    assign pg_rem   = DW'(r_quo) - np_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tok <= i_token_id;
            r_dph <= DPH_QUO;
        end else if (i_cmd.div_step) begin
            r_dph <= r_dph + 1'b1;
            if (r_dph == DPH_QUO) begin
                r_quo <= quo_prod[QSH +: TOKEN_W];
            end
            if (r_dph == DPH_NUM) begin
                r_qnp <= qnp_prod[NSH +: TOKEN_W];
            end
            if (r_dph == DPH_LAST) begin
                r_page <= pg_rem[PW-1:0];
            end
        end
    end

    // Page table memory.
    logic           mem_we;
    logic [PW-1:0]  mem_waddr, mem_raddr, r_sc;
    t_entry         mem_wdata, rd_ent;
    logic [ENTRY_W-1:0] mem_rdata;

    kvpem_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_PAGES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_ent    = t_entry'(mem_rdata);
    assign mem_raddr = i_cmd.scan_step ? r_sc : r_page;

    // Entry update for touch, pin and unpin.
    function automatic t_entry apply_op(t_entry e, t_op op, logic [SCORE_W-1:0] w);
        t_entry r;
        r = e;
        case (op)
            OP_TOUCH: begin
                if (w > e.score) begin
                    r.score = w;
                end
                r.present = 1'b1;
            end
            OP_PIN: begin
                if (e.pins != PIN_MAX) begin
                    r.pins = e.pins + 1'b1;
                end
            end
            OP_UNPIN: begin
                if (e.pins != '0) begin
                    r.pins = e.pins - 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Scan state and best candidate.
    t_entry           r_ent;
    logic             r_sv, r_found;
    logic [PW-1:0]    r_sa, r_bidx;
    logic [SCORE_W-1:0] r_bscore;
    logic [PIN_W-1:0] r_bpins;
    logic [CNT_W-1:0] r_target, r_done;
    logic [TW-1:0]    r_total;
    logic             cand;
    t_entry           src_ent;
    logic [CNT_W-1:0] tgt_mux;

    assign cand    = r_sv && rd_ent.present && (rd_ent.pins == '0);
    assign src_ent = i_cmd.apply_ent ? r_ent : rd_ent;
    assign tgt_mux = (r_op == OP_TOUCH) ? r_band : r_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step || i_cmd.clear) begin
            r_sc <= (r_sc == PG_LAST) ? '0 : r_sc + 1'b1;
        end
        if (!i_rst_n) begin
            r_sc <= '0;
        end
        r_sa <= r_sc;
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else begin
            r_sv <= i_cmd.scan_step;
        end
        if (i_cmd.load_tgt) begin
            r_target <= tgt_mux;
        end
        // A page is latched when its look-up starts an eviction.
        if (i_cmd.load_tgt) begin
            r_ent <= rd_ent;
        end
        if (i_cmd.load_tgt || i_cmd.ev_write) begin
            r_found <= 1'b0;
        end else if (cand && (!r_found || (rd_ent.score < r_bscore))) begin
            r_found  <= 1'b1;
            r_bidx   <= r_sa;
            r_bscore <= rd_ent.score;
            r_bpins  <= rd_ent.pins;
        end
        if (i_cmd.accept) begin
            r_done <= '0;
        end else if (i_cmd.ev_write && r_found) begin
            r_done <= r_done + 1'b1;
        end
    end

    // Resident page count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cmd.ev_write && r_found) begin
            if (r_total != '0) begin
                r_total <= r_total - 1'b1;
            end
        end else if ((i_cmd.apply_rd || i_cmd.apply_ent) && (r_op == OP_TOUCH)
                     && !src_ent.present) begin
            r_total <= r_total + 1'b1;
        end
    end

    // Memory write selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_page;
        mem_wdata = apply_op(src_ent, r_op, r_weight);
        if (i_cmd.clear) begin
            mem_we    = 1'b1;
            mem_waddr = r_sc;
            mem_wdata = '0;
        end else if (i_cmd.ev_write) begin
            mem_we    = r_found;
            mem_waddr = r_bidx;
            mem_wdata = '{pins: r_bpins, present: 1'b0, score: '0};
        end else if (i_cmd.apply_rd || i_cmd.apply_ent) begin
            mem_we = 1'b1;
        end
    end

    // Result register.
    logic             r_rsp_valid;
    logic [CNT_W-1:0] r_evicted, r_resident;
    logic [CMPW-1:0]  total_x;

    assign total_x = CMPW'(r_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_evicted  <= r_done;
            r_resident <= total_x[CNT_W-1:0];
        end
    end

    assign o_rsp_valid      = r_rsp_valid;
    assign o_evicted_pages  = r_evicted;
    assign o_resident_pages = r_resident;

    // Status.
    always_comb begin
        o_sts.clr_last  = (r_sc == PG_LAST);
        o_sts.div_done  = (r_dph == DPH_LAST);
        o_sts.scan_last = (r_sc == PG_LAST);
        o_sts.is_touch  = (r_op == OP_TOUCH);
        o_sts.is_evict  = (r_op == OP_EVICT);
        o_sts.present   = rd_ent.present;
        o_sts.trigger   = (total_x >= CMPW'(r_max_res));
        o_sts.tgt_zero  = (tgt_mux == '0);
        o_sts.ev_more   = r_found && ({1'b0, r_done} + 1'b1 < {1'b0, r_target});
        o_sts.out_free  = !r_rsp_valid || i_rsp_ready;
    end
endmodule

// ----- src/kvpem_checker.sv -----
`include "kv_page_eviction_manager_core_defines.svh"

module kvpem_checker import kvpem_pkg::*; #(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input logic [CNT_W-1:0] i_resident_pages,
    input logic [CNT_W-1:0] i_evicted_pages
);
    localparam int CW = $clog2(NUM_PAGES + 1) + 1;
    logic [CW-1:0] res_x;
    assign res_x = CW'(i_resident_pages);

    // Nothing is reported during or right after reset.
    `KVPEM_ASSERT_NEXT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n, !i_rsp_valid)
    // An accepted transaction keeps the block busy for the next cycle.
    `KVPEM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)
    // A stalled result stays put.
    `KVPEM_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_resident_pages) && $stable(i_evicted_pages))
    // The resident count never exceeds the table size.
    `KVPEM_ASSERT_IMPLY(a_res_bound, i_clk, i_rst_n, i_rsp_valid, res_x <= CW'(NUM_PAGES))
endmodule

bind kv_page_eviction_manager_core kvpem_checker #(.NUM_PAGES(NUM_PAGES)) u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_resident_pages (o_rsp.resident_pages),
    .i_evicted_pages  (o_rsp.evicted_pages)
);
